### rtl/mnss_pkg.sv
// ----------------------------------------------------------------------------
// Multi-needle substring search: shared definitions
// Sizes of the needle store and window, derived widths and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mnss_pkg;

    // Needle store geometry.
    localparam int NEEDLES = 8;
    localparam int MAX_LEN = 16;

    // Derived widths.
    localparam int NSEL_W = (NEEDLES > 1) ? $clog2(NEEDLES) : 1;
    localparam int CNT_W  = $clog2(NEEDLES + 1);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 3;
    localparam int BSLOT_W  = 4;
    localparam int BYTE_W   = 8;
    localparam int PLEN_W   = 5;
    localparam int OFFS_W   = 32;
    localparam int POS_W    = 32;
    localparam int NIU_W    = 4;
    localparam int CHAIN_W  = 8;
    localparam int CFG_IDX_W = 1;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 80;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_RESTART    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_BYTE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_LENGTH = 2'd2;
    localparam logic [CMD_W-1:0] CMD_HAYSTACK   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLES_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_TAG      = 1'd1;

endpackage

`default_nettype wire

### rtl/mnss_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mnss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire                               aclk,
    input  wire                               wr_en,
    input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]                  wr_data,
    input  wire  [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/multi_needle_substring_search.sv
// ----------------------------------------------------------------------------
// Multi-needle substring search
// Streams haystack bytes and reports every stored needle that ends at each.
// ----------------------------------------------------------------------------
// Needle bytes, needle lengths and haystack restarts arrive as command words on
// the input stream; command words are taken only while the block is idle. A
// haystack byte enters the window, then each needle in use is read and compared
// in turn (the needle store has a single read port and every needle goes through
// the same shift-and-compare unit), then one match word leaves per match found,
// or the block passes once through its emit state if nothing matched, with
// needles_in_use counted as at most eight. While a result word waits on the
// output, the block can neither load the next match word nor leave its emit
// state. Matches leave in needle order, the final one of a byte with tlast set.
// The final match word of a byte may wait on the output while the next input
// word is taken.
`default_nettype none

module multi_needle_substring_search (
    input  wire                                aclk,
    input  wire                                aresetn,
    // cmd, needle_slot, byte_slot, byte_value, pattern_length, source_offset
    input  wire  [mnss_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // match_needle, match_position, match_origin, match_chain
    output logic [mnss_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    input  wire                                cfg_wr_en,
    input  wire  [mnss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [mnss_pkg::CHAIN_W-1:0]       cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam int WIN_BITS = mnss_pkg::MAX_LEN * mnss_pkg::BYTE_W;

    // Input fields.
    logic [mnss_pkg::CMD_W-1:0]   in_cmd;
    logic [mnss_pkg::SLOT_W-1:0]  in_slot;
    logic [mnss_pkg::BSLOT_W-1:0] in_bslot;
    logic [mnss_pkg::BYTE_W-1:0]  in_byte;
    logic [mnss_pkg::PLEN_W-1:0]  in_plen;
    logic [mnss_pkg::OFFS_W-1:0]  in_offset;
    logic                         in_acc;

    assign in_cmd    = s_tdata[1:0];
    assign in_slot   = s_tdata[4:2];
    assign in_bslot  = s_tdata[8:5];
    assign in_byte   = s_tdata[16:9];
    assign in_plen   = s_tdata[21:17];
    assign in_offset = s_tdata[53:22];

    // State.
    logic [1:0]                        state_reg, state_next;
    logic [mnss_pkg::CNT_W-1:0]        ctr_reg, ctr_next;
    logic [mnss_pkg::NEEDLES-1:0]      mask_reg, mask_next;
    logic [mnss_pkg::POS_W-1:0]        count_reg, count_next;
    logic [mnss_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [mnss_pkg::NIU_W-1:0]        niu_reg;
    logic [mnss_pkg::CHAIN_W-1:0]      chain_reg;
    logic [mnss_pkg::LEN_W-1:0]        len_reg [mnss_pkg::NEEDLES];
    logic [mnss_pkg::MAX_LEN-1:0][mnss_pkg::BYTE_W-1:0] win_reg;
    logic [mnss_pkg::OFFS_W-1:0]       origin_reg [mnss_pkg::MAX_LEN];

    logic                              out_valid_reg, out_valid_next;
    logic [mnss_pkg::SLOT_W-1:0]       out_needle_reg, out_needle_next;
    logic [mnss_pkg::POS_W-1:0]        out_pos_reg, out_pos_next;
    logic [mnss_pkg::OFFS_W-1:0]       out_origin_reg, out_origin_next;
    logic [mnss_pkg::CHAIN_W-1:0]      out_chain_reg, out_chain_next;
    logic                              out_last_reg, out_last_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_chain_reg, out_origin_reg, out_pos_reg, out_needle_reg};

    // Needle store: one RAM per byte lane, addressed by needle.
    logic [mnss_pkg::MAX_LEN-1:0]                       lane_we;
    logic [mnss_pkg::MAX_LEN-1:0][mnss_pkg::BYTE_W-1:0] lane_rd;
    logic                                               slot_ok;

    assign slot_ok = (32'(in_slot) < mnss_pkg::NEEDLES);

    for (genvar k = 0; k < mnss_pkg::MAX_LEN; k++) begin : g_lane
        assign lane_we[k] = in_acc && (in_cmd == mnss_pkg::CMD_WRITE_BYTE) && slot_ok
                            && (32'(in_bslot) == k);

        mnss_ram #(
            .WIDTH (mnss_pkg::BYTE_W),
            .DEPTH (mnss_pkg::NEEDLES)
        ) u_lane (
            .aclk    (aclk),
            .wr_en   (lane_we[k]),
            .wr_addr (mnss_pkg::NSEL_W'(in_slot)),
            .wr_data (in_byte),
            .rd_addr (ctr_reg[mnss_pkg::NSEL_W-1:0]),
            .rd_data (lane_rd[k])
        );
    end

    // Needles taking part.
    logic [mnss_pkg::CNT_W-1:0] used;
    assign used = (32'(niu_reg) > mnss_pkg::NEEDLES) ? mnss_pkg::CNT_W'(mnss_pkg::NEEDLES)
                                                     : mnss_pkg::CNT_W'(niu_reg);

    // Lowest pending match.
    logic [mnss_pkg::NSEL_W-1:0]  sel_idx;
    logic [mnss_pkg::NEEDLES-1:0] mask_rest;

    always_comb begin
        sel_idx = '0;
        for (int i = mnss_pkg::NEEDLES - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel_idx = mnss_pkg::NSEL_W'(i);
            end
        end
        mask_rest = mask_reg;
        mask_rest[sel_idx] = 1'b0;
    end

    // Single length read: the needle being compared while scanning, the needle
    // being reported while emitting.
    logic [mnss_pkg::NSEL_W-1:0] len_ptr;
    logic [mnss_pkg::LEN_W-1:0]  len_rd;
    logic [mnss_pkg::NSEL_W-1:0] cmp_idx;

    assign cmp_idx = mnss_pkg::NSEL_W'(ctr_reg - mnss_pkg::CNT_W'(1));
    assign len_ptr = (state_reg == ST_SCAN) ? cmp_idx : sel_idx;
    assign len_rd  = len_reg[len_ptr];

    // Shared compare unit. The needle is laid out reversed, then shifted so
    // that its last byte lines up with the newest window byte.
    logic [WIN_BITS-1:0]         rev_vec, shifted_vec, win_vec, diff_vec;
    logic [mnss_pkg::LEN_W-1:0]  shift_lanes;
    logic [mnss_pkg::MAX_LEN-1:0] lane_mask;
    logic                        hit;

    assign win_vec     = win_reg;
    assign shift_lanes = mnss_pkg::LEN_W'(mnss_pkg::MAX_LEN) - len_rd;
    assign shifted_vec = rev_vec >> {shift_lanes, 3'b000};
    assign diff_vec    = shifted_vec ^ win_vec;

    always_comb begin
        rev_vec = '0;
        for (int j = 0; j < mnss_pkg::MAX_LEN; j++) begin
            rev_vec[j*mnss_pkg::BYTE_W +: mnss_pkg::BYTE_W] = lane_rd[mnss_pkg::MAX_LEN-1-j];
        end
    end

    always_comb begin
        lane_mask = '0;
        hit       = (len_rd != '0) && (count_reg >= 32'(len_rd));
        for (int j = 0; j < mnss_pkg::MAX_LEN; j++) begin
            lane_mask[j] = (32'(len_rd) > j);
            if (lane_mask[j] && (diff_vec[j*mnss_pkg::BYTE_W +: mnss_pkg::BYTE_W] != '0)) begin
                hit = 1'b0;
            end
        end
    end

    // Sequencer and output register.
    logic can_load;
    assign can_load = !out_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        ctr_next        = ctr_reg;
        mask_next       = mask_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_needle_next = out_needle_reg;
        out_pos_next    = out_pos_reg;
        out_origin_next = out_origin_reg;
        out_chain_next  = out_chain_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        mnss_pkg::CMD_RESTART: begin
                            count_next = '0;
                        end
                        mnss_pkg::CMD_HAYSTACK: begin
                            pos_next = count_reg;
                            if (count_reg != '1) begin
                                count_next = count_reg + 32'd1;
                            end
                            ctr_next   = '0;
                            mask_next  = '0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // RAM data in this cycle belongs to the previous needle address.
                if ((ctr_reg != '0) && hit) begin
                    mask_next[cmp_idx] = 1'b1;
                end
                if (ctr_reg == used) begin
                    state_next = ST_EMIT;
                end else begin
                    ctr_next = ctr_reg + mnss_pkg::CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    if (mask_reg != '0) begin
                        out_valid_next  = 1'b1;
                        out_needle_next = mnss_pkg::SLOT_W'(sel_idx);
                        out_pos_next    = pos_reg - 32'(len_rd) + 32'd1;
                        out_origin_next =
                            origin_reg[mnss_pkg::IDX_W'(len_rd - mnss_pkg::LEN_W'(1))];
                        out_chain_next  = chain_reg;
                        out_last_next   = (mask_rest == '0);
                        mask_next       = mask_rest;
                        if (mask_rest == '0) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ctr_reg       <= '0;
            mask_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            mask_reg      <= mask_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        pos_reg        <= pos_next;
        out_needle_reg <= out_needle_next;
        out_pos_reg    <= out_pos_next;
        out_origin_reg <= out_origin_next;
        out_chain_reg  <= out_chain_next;
        out_last_reg   <= out_last_next;
    end

    // Window of recent bytes and their original offsets, newest in lane zero.
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_acc && (in_cmd == mnss_pkg::CMD_RESTART))) begin
            win_reg <= '0;
            for (int i = 0; i < mnss_pkg::MAX_LEN; i++) begin
                origin_reg[i] <= '0;
            end
        end else if (in_acc && (in_cmd == mnss_pkg::CMD_HAYSTACK)) begin
            win_reg[0]    <= in_byte;
            origin_reg[0] <= in_offset;
            for (int i = 1; i < mnss_pkg::MAX_LEN; i++) begin
                win_reg[i]    <= win_reg[i-1];
                origin_reg[i] <= origin_reg[i-1];
            end
        end
    end

    // Needle lengths, saturated to the store width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mnss_pkg::NEEDLES; i++) begin
                len_reg[i] <= '0;
            end
        end else if (in_acc && (in_cmd == mnss_pkg::CMD_SET_LENGTH) && slot_ok) begin
            if (32'(in_plen) > mnss_pkg::MAX_LEN) begin
                len_reg[mnss_pkg::NSEL_W'(in_slot)] <= mnss_pkg::LEN_W'(mnss_pkg::MAX_LEN);
            end else begin
                len_reg[mnss_pkg::NSEL_W'(in_slot)] <= mnss_pkg::LEN_W'(in_plen);
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            niu_reg   <= '0;
            chain_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mnss_pkg::CFG_NEEDLES_IN_USE: niu_reg   <= cfg_data[mnss_pkg::NIU_W-1:0];
                mnss_pkg::CFG_CHAIN_TAG:      chain_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### tb/sv/multi_needle_substring_search_test.sv
// ----------------------------------------------------------------------------
// Multi-needle substring search: block-level test
// Streams needle loads, restarts and haystack words into the block. A local
// model of the needle store and window predicts every match, and the match
// words are checked field by field as they leave under random back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_needle_substring_search_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 32;
    localparam int REPORT_MAX   = 10;

    // Input word, first field in the lowest bits.
    typedef struct packed {
        logic [mnss_pkg::S_TDATA_W-54-1:0] pad;
        logic [mnss_pkg::OFFS_W-1:0]       source_offset;
        logic [mnss_pkg::PLEN_W-1:0]       pattern_length;
        logic [mnss_pkg::BYTE_W-1:0]       byte_value;
        logic [mnss_pkg::BSLOT_W-1:0]      byte_slot;
        logic [mnss_pkg::SLOT_W-1:0]       needle_slot;
        logic [mnss_pkg::CMD_W-1:0]        cmd;
    } cmd_word_t;

    // Match word, first field in the lowest bits.
    typedef struct packed {
        logic [mnss_pkg::M_TDATA_W-75-1:0] pad;
        logic [mnss_pkg::CHAIN_W-1:0]      chain;
        logic [mnss_pkg::OFFS_W-1:0]       origin;
        logic [mnss_pkg::POS_W-1:0]        position;
        logic [mnss_pkg::SLOT_W-1:0]       needle;
    } match_word_t;

    typedef struct packed {
        logic        last;
        match_word_t word;
    } match_t;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic [mnss_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [mnss_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                             m_tlast;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [mnss_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [mnss_pkg::CHAIN_W-1:0]     cfg_data  = '0;

    multi_needle_substring_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Local copy of the block's state.
    logic [mnss_pkg::BYTE_W-1:0]  pat_bytes   [mnss_pkg::NEEDLES][mnss_pkg::MAX_LEN];
    logic [mnss_pkg::MAX_LEN-1:0] pat_written [mnss_pkg::NEEDLES];
    int unsigned                  pat_len     [mnss_pkg::NEEDLES];
    logic [mnss_pkg::BYTE_W-1:0]  hist_bytes  [mnss_pkg::MAX_LEN];
    logic [mnss_pkg::OFFS_W-1:0]  hist_origin [mnss_pkg::MAX_LEN];
    logic [mnss_pkg::POS_W-1:0]   hay_count;
    logic [mnss_pkg::NIU_W-1:0]   niu_reg;
    logic [mnss_pkg::CHAIN_W-1:0] chain_reg;

    match_t pending_matches[$];

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned words_sent    = 0;
    int unsigned hay_sent      = 0;
    int unsigned matches_seen  = 0;
    int unsigned settings_done = 0;
    int unsigned busiest_byte  = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_taken    = 0;
    int unsigned hold_left     = 0;
    int unsigned rx_gap_left   = 0;
    bit          rx_steady     = 1'b0;
    bit          tx_steady     = 1'b0;
    logic [mnss_pkg::OFFS_W-1:0] origin_cursor;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned written_prefix(int unsigned slot);
        int unsigned p;
        p = 0;
        while (p < mnss_pkg::MAX_LEN && pat_written[slot][p]) p++;
        return p;
    endfunction

    function automatic logic [mnss_pkg::OFFS_W-1:0] next_origin();
        if ($urandom_range(0, 19) == 0) origin_cursor = $urandom;
        else origin_cursor = origin_cursor + $urandom_range(1, 4);
        return origin_cursor;
    endfunction

    // Haystack text mostly comes from a three-letter alphabet so that needles hit.
    function automatic logic [mnss_pkg::BYTE_W-1:0] text_byte();
        if ($urandom_range(0, 9) < 8) return mnss_pkg::BYTE_W'(8'h61 + $urandom_range(0, 2));
        return mnss_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic cmd_word_t random_word();
        cmd_word_t w;
        w.pad            = '0;
        w.source_offset  = $urandom;
        w.pattern_length = mnss_pkg::PLEN_W'($urandom_range(0, 31));
        w.byte_value     = mnss_pkg::BYTE_W'($urandom_range(0, 255));
        w.byte_slot      = mnss_pkg::BSLOT_W'($urandom_range(0, 15));
        w.needle_slot    = mnss_pkg::SLOT_W'($urandom_range(0, 7));
        w.cmd            = mnss_pkg::CMD_W'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < mnss_pkg::MAX_LEN; i++) begin
            hist_bytes[i]  = '0;
            hist_origin[i] = '0;
        end
        hay_count = '0;
    endfunction

    // Applies one accepted word to the local state and queues its matches.
    function automatic void predict_matches(cmd_word_t w);
        match_t      hits[$];
        match_t      m;
        logic [mnss_pkg::POS_W-1:0] pos;
        int unsigned used;
        int unsigned len;
        bit          equal;
        case (w.cmd)
            mnss_pkg::CMD_RESTART: begin
                clear_window();
            end
            mnss_pkg::CMD_WRITE_BYTE: begin
                pat_bytes[w.needle_slot][w.byte_slot] = w.byte_value;
                pat_written[w.needle_slot][w.byte_slot] = 1'b1;
            end
            mnss_pkg::CMD_SET_LENGTH: begin
                pat_len[w.needle_slot] = (w.pattern_length > mnss_pkg::MAX_LEN) ?
                                         mnss_pkg::MAX_LEN : w.pattern_length;
            end
            default: begin
                for (int i = mnss_pkg::MAX_LEN - 1; i > 0; i--) begin
                    hist_bytes[i]  = hist_bytes[i-1];
                    hist_origin[i] = hist_origin[i-1];
                end
                hist_bytes[0]  = w.byte_value;
                hist_origin[0] = w.source_offset;
                pos = hay_count;
                if (hay_count != '1) hay_count = hay_count + 1'b1;
                used = (niu_reg > mnss_pkg::NEEDLES) ? mnss_pkg::NEEDLES : niu_reg;
                for (int n = 0; n < used; n++) begin
                    len = pat_len[n];
                    if (len == 0 || hay_count < len) continue;
                    equal = 1'b1;
                    for (int k = 0; k < len; k++)
                        if (pat_bytes[n][k] != hist_bytes[len-1-k]) equal = 1'b0;
                    if (!equal) continue;
                    m.last          = 1'b0;
                    m.word.pad      = '0;
                    m.word.needle   = mnss_pkg::SLOT_W'(n);
                    m.word.position = pos - mnss_pkg::POS_W'(len - 1);
                    m.word.origin   = hist_origin[len-1];
                    m.word.chain    = chain_reg;
                    hits.push_back(m);
                end
                if (hits.size() > 0) hits[hits.size()-1].last = 1'b1;
                if (hits.size() > busiest_byte) busiest_byte = hits.size();
                foreach (hits[i]) pending_matches.push_back(hits[i]);
                hay_sent++;
            end
        endcase
    endfunction

    task automatic note_mismatch(string msg);
        if (mismatches < REPORT_MAX) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Sends one word; called and returning just after a rising edge.
    task automatic send_word(cmd_word_t w);
        int unsigned gap;
        gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_matches(w);
        words_sent++;
    endtask

    task automatic send_haystack(logic [mnss_pkg::BYTE_W-1:0] value,
                                 logic [mnss_pkg::OFFS_W-1:0] offset);
        cmd_word_t w;
        w = random_word();
        w.cmd           = mnss_pkg::CMD_HAYSTACK;
        w.byte_value    = value;
        w.source_offset = offset;
        send_word(w);
    endtask

    task automatic send_restart();
        cmd_word_t w;
        w = random_word();
        w.cmd = mnss_pkg::CMD_RESTART;
        send_word(w);
    endtask

    task automatic send_length(int unsigned slot, logic [mnss_pkg::PLEN_W-1:0] plen);
        cmd_word_t w;
        w = random_word();
        w.cmd            = mnss_pkg::CMD_SET_LENGTH;
        w.needle_slot    = mnss_pkg::SLOT_W'(slot);
        w.pattern_length = plen;
        send_word(w);
    endtask

    task automatic send_needle_byte(int unsigned slot, int unsigned idx,
                                    logic [mnss_pkg::BYTE_W-1:0] value);
        cmd_word_t w;
        w = random_word();
        w.cmd         = mnss_pkg::CMD_WRITE_BYTE;
        w.needle_slot = mnss_pkg::SLOT_W'(slot);
        w.byte_slot   = mnss_pkg::BSLOT_W'(idx);
        w.byte_value  = value;
        send_word(w);
    endtask

    // Writes bytes 0 .. len-1 before the length, so no unwritten byte is compared.
    task automatic load_needle(int unsigned slot, int unsigned len,
                               logic [mnss_pkg::PLEN_W-1:0] plen);
        for (int k = 0; k < len; k++) send_needle_byte(slot, k, text_byte());
        send_length(slot, plen);
    endtask

    task automatic write_register(logic [mnss_pkg::CFG_IDX_W-1:0] idx,
                                  logic [mnss_pkg::CHAIN_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        if (idx == mnss_pkg::CFG_NEEDLES_IN_USE) niu_reg = value[mnss_pkg::NIU_W-1:0];
        else chain_reg = value;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits for every match, then lets a word with no matches finish its pass.
    task automatic wait_until_idle();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(int unsigned niu, logic [mnss_pkg::CHAIN_W-1:0] chain);
        wait_until_idle();
        write_register(mnss_pkg::CFG_NEEDLES_IN_USE,
                       {4'($urandom_range(0, 15)), 4'(niu)});
        write_register(mnss_pkg::CFG_CHAIN_TAG, chain);
        settings_done++;
    endtask

    // Mostly well-formed needle loads and text runs, with some noise around them.
    task automatic send_random_mix(int unsigned count);
        int unsigned stop_at;
        int unsigned r;
        int unsigned slot;
        int unsigned len;
        int unsigned p;
        cmd_word_t   w;
        stop_at = words_sent + count;
        while (words_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
            r    = $urandom_range(0, 99);
            slot = $urandom_range(0, mnss_pkg::NEEDLES - 1);
            if (r < 15) begin
                if ($urandom_range(0, 4) == 0) begin
                    load_needle(slot, mnss_pkg::MAX_LEN,
                                mnss_pkg::PLEN_W'($urandom_range(mnss_pkg::MAX_LEN, 31)));
                end else begin
                    len = $urandom_range(1, 4);
                    load_needle(slot, len, mnss_pkg::PLEN_W'(len));
                end
            end else if (r < 65) begin
                if ($urandom_range(0, 1) == 0 && pat_len[slot] != 0) begin
                    for (int k = 0; k < pat_len[slot]; k++)
                        send_haystack(pat_bytes[slot][k], next_origin());
                end
                repeat ($urandom_range(3, 10)) send_haystack(text_byte(), next_origin());
            end else if (r < 80) begin
                w = random_word();
                w.cmd = mnss_pkg::CMD_WRITE_BYTE;
                send_word(w);
            end else if (r < 88) begin
                p = written_prefix(slot);
                send_length(slot, (p == mnss_pkg::MAX_LEN) ?
                                  mnss_pkg::PLEN_W'($urandom_range(0, 31)) :
                                  mnss_pkg::PLEN_W'($urandom_range(0, p)));
            end else if (r < 93) begin
                send_restart();
            end else begin
                w = random_word();
                w.cmd = mnss_pkg::CMD_HAYSTACK;
                send_word(w);
            end
        end
        tx_steady = 1'b0;
    endtask

    task automatic test_registers_after_reset();
        // Nothing is in use after reset, so text produces no matches.
        send_haystack(8'h00, 32'h0000_0000);
        send_haystack(8'hFF, 32'hFFFF_FFFF);
        send_haystack(8'h61, 32'h1234_5678);
    endtask

    task automatic test_directed_matches();
        configure(mnss_pkg::NEEDLES, 8'hA5);
        send_needle_byte(0, 0, 8'h61);
        send_needle_byte(0, 1, 8'h62);
        send_length(0, 5'd2);
        send_needle_byte(1, 0, 8'h62);
        send_length(1, 5'd1);
        send_needle_byte(7, mnss_pkg::MAX_LEN - 1, 8'hFF);
        send_restart();
        // The two-byte needle is too long for the first text byte after a restart.
        send_haystack(8'h61, 32'hFFFF_FFFF);
        send_haystack(8'h62, 32'h0000_0000);
        send_haystack(8'h62, 32'h0000_0005);
        send_length(1, 5'd0);
        send_haystack(8'h62, 32'h0000_0006);
        send_haystack(8'hFF, 32'h8000_0000);
        send_haystack(8'h00, 32'h7FFF_FFFF);
        send_length(0, 5'd1);
        send_haystack(8'h61, 32'h0000_0010);
        send_restart();
        send_haystack(8'h62, 32'h0000_0020);
        send_haystack(8'h61, 32'h0000_0021);
    endtask

    task automatic test_needle_count_sweep();
        int unsigned niu_list [6] = '{1, mnss_pkg::NEEDLES, mnss_pkg::NEEDLES + 1, 15, 0, 4};
        int unsigned chain_list [6];
        chain_list = '{8'h00, 8'hFF, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 255)};
        foreach (niu_list[i]) begin
            configure(niu_list[i], mnss_pkg::CHAIN_W'(chain_list[i]));
            send_random_mix(30);
        end
    endtask

    task automatic test_output_backpressure();
        configure(mnss_pkg::NEEDLES, mnss_pkg::CHAIN_W'($urandom_range(0, 255)));
        for (int n = 0; n < mnss_pkg::NEEDLES; n++) begin
            for (int k = 0; k <= n % 2; k++) send_needle_byte(n, k, 8'h7A);
            send_length(n, mnss_pkg::PLEN_W'((n % 2) + 1));
        end
        // The receiver stops for a long stretch while every needle hits each word from the second on.
        hold_requests++;
        tx_steady = 1'b1;
        repeat (40) send_haystack(8'h7A, next_origin());
        tx_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        configure(mnss_pkg::NEEDLES, mnss_pkg::CHAIN_W'($urandom_range(0, 255)));
        send_random_mix(80);
        configure($urandom_range(2, 7), mnss_pkg::CHAIN_W'($urandom_range(0, 255)));
        send_random_mix(40);
    endtask

    // Receiver side: random stalls, stretches without stalls, and the long hold.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_taken != hold_requests) begin
            hold_taken <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (rx_gap_left != 0) begin
            rx_gap_left <= rx_gap_left - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0) rx_gap_left <= pick_gap();
        end
        if ($urandom_range(0, 255) == 0) rx_steady <= !rx_steady;
    end

    // Match checker.
    always @(posedge aclk) begin
        match_word_t got;
        match_t      want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            matches_seen++;
            if (pending_matches.size() == 0) begin
                note_mismatch($sformatf("unexpected match word, needle %0d position %h",
                                        got.needle, got.position));
            end else begin
                want = pending_matches.pop_front();
                if (got !== want.word || m_tlast !== want.last)
                    note_mismatch($sformatf(
                        "needle %0d/%0d pos %h/%h origin %h/%h chain %h/%h last %b/%b pad %h",
                        want.word.needle, got.needle, want.word.position, got.position,
                        want.word.origin, got.origin, want.word.chain, got.chain,
                        want.last, m_tlast, got.pad));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d matches outstanding.",
                     cycle_count, pending_matches.size());
            $display("multi_needle_substring_search verification failed");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < mnss_pkg::NEEDLES; n++) begin
            pat_written[n] = '0;
            pat_len[n]     = 0;
            for (int k = 0; k < mnss_pkg::MAX_LEN; k++) pat_bytes[n][k] = '0;
        end
        clear_window();
        niu_reg       = '0;
        chain_reg     = '0;
        origin_cursor = $urandom;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_registers_after_reset();
        test_directed_matches();
        test_needle_count_sweep();
        test_output_backpressure();
        test_random_traffic();
        wait_until_idle();

        if (pending_matches.size() != 0)
            note_mismatch($sformatf("%0d matches never arrived", pending_matches.size()));
        $display("Covered %0d input words, %0d of them haystack bytes, over %0d settings.",
                 words_sent, hay_sent, settings_done);
        $display("Checked %0d match words, at most %0d from one byte, %0d mismatches.",
                 matches_seen, busiest_byte, mismatches);
        if (mismatches == 0) begin
            $display("multi_needle_substring_search verification clean");
        end else begin
            $display("multi_needle_substring_search verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/mnss_pkg.sv
rtl/mnss_ram.sv
rtl/multi_needle_substring_search.sv
tb/sv/multi_needle_substring_search_test.sv
